/* sv/keyword_substitution_cipher_top_macros.svh */
// assertion macros for the keyword substitution cipher
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define KSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksc assertion failed");

// next-cycle implication, checked outside reset
`define KSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksc assertion failed");

`endif

/* sv/ksc_pkg.sv */
// shared types, constants and helpers for the keyword substitution cipher
package ksc_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // operation codes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  typedef struct packed {
    logic                valid;
    logic                lower;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // commands from controller to datapath
  typedef struct packed {
    logic                key_en;
    logic                text_en;
    logic                walk_en;
    logic                walk_last;
    logic [LETTER_W-1:0] walk_idx;
  } ksc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic alphabet_complete;
  } ksc_stat_t;

  // classify a byte as upper/lower ascii letter and give its index
  function automatic letter_t decode_letter(input logic [7:0] c);
    letter_t l;
    l = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      l.valid = 1'b1;
      l.idx   = LETTER_W'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      l.valid = 1'b1;
      l.lower = 1'b1;
      l.idx   = LETTER_W'(c - CHAR_LOWER_A);
    end
    return l;
  endfunction

endpackage

/* sv/ksc_ctrl.sv */
// controller: handshakes, finish walk sequencer and output valid
module ksc_ctrl
  import ksc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ksc_stat_t  stat,
  output ksc_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                state_r, state_nxt;
  logic [LETTER_W-1:0] walk_r, walk_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;

  // take a new word when idle and the output slot is free or draining
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.key_en    = in_fire && (in_operation == OP_KEY);
    cmd.text_en   = in_fire && (in_operation == OP_TEXT);
    cmd.walk_en   = (state_r == ST_WALK);
    cmd.walk_last = (state_r == ST_WALK) && (walk_r == '0);
    cmd.walk_idx  = walk_r;
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_operation == OP_FINISH) && !stat.alphabet_complete) begin
          state_nxt = ST_WALK;
          walk_nxt  = LETTER_W'(NUM_LETTERS - 1);
        end
      end
      ST_WALK: begin
        if (walk_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.text_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ksc_datapath.sv */
// datapath: alphabet tables, letter bookkeeping, mode register and result byte
module ksc_datapath
  import ksc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ksc_cmd_t   cmd,
  input  logic [7:0] in_char_in,
  input  logic       mode_wr,
  input  logic       mode_din,
  output ksc_stat_t  stat,
  output logic [7:0] out_char_out
);

  logic [LETTER_W-1:0]    fwd_r [NUM_LETTERS];
  logic [LETTER_W-1:0]    inv_r [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] used_r, used_nxt, base_used;
  logic [LETTER_W-1:0]    fill_r, fill_nxt, base_fill;
  logic                   complete_r, complete_nxt;
  logic                   mode_r;
  logic [7:0]             char_r, char_nxt;

  letter_t             dec;
  logic [LETTER_W-1:0] cand_k;
  logic                cand_ok;
  logic                place;
  logic [LETTER_W-1:0] map_raw, map_idx;

  assign dec = decode_letter(in_char_in);

  // a keyword word after a finished alphabet starts from empty
  always_comb begin
    base_used = used_r;
    base_fill = fill_r;
    if (cmd.key_en && complete_r) begin
      base_used = '0;
      base_fill = '0;
    end
  end

  // pick the letter to append: keyword letter or walk index
  assign cand_k  = cmd.walk_en ? cmd.walk_idx : dec.idx;
  assign cand_ok = cmd.walk_en || (cmd.key_en && dec.valid);
  assign place   = cand_ok && !base_used[cand_k] &&
                   (base_fill < LETTER_W'(NUM_LETTERS));

  always_comb begin
    used_nxt = base_used;
    fill_nxt = base_fill;
    if (place) begin
      used_nxt = base_used | (NUM_LETTERS'(1) << cand_k);
      fill_nxt = base_fill + 1'b1;
    end
  end

  // completion flag
  always_comb begin
    complete_nxt = complete_r;
    if (cmd.key_en) begin
      complete_nxt = 1'b0;
    end else if (cmd.walk_last) begin
      complete_nxt = 1'b1;
    end
  end

  // text lookup, clamped to the last letter
  assign map_raw = mode_r ? inv_r[dec.idx] : fwd_r[dec.idx];
  assign map_idx = (map_raw >= LETTER_W'(NUM_LETTERS)) ? LETTER_W'(NUM_LETTERS - 1)
                                                      : map_raw;

  always_comb begin
    char_nxt = in_char_in;
    if (complete_r && dec.valid) begin
      char_nxt = (dec.lower ? CHAR_LOWER_A : CHAR_UPPER_A) + {3'b000, map_idx};
    end
  end

  // tables reset to the empty-keyword alphabet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        fwd_r[i] <= LETTER_W'(NUM_LETTERS - 1 - i);
        inv_r[i] <= LETTER_W'(NUM_LETTERS - 1 - i);
      end
    end else if (place) begin
      fwd_r[base_fill] <= cand_k;
      inv_r[cand_k]    <= base_fill;
    end
  end

  // bookkeeping and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '1;
      fill_r     <= LETTER_W'(NUM_LETTERS);
      complete_r <= 1'b1;
      mode_r     <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      complete_r <= complete_nxt;
      if (mode_wr) begin
        mode_r <= mode_din;
      end
    end
  end

  // result byte register
  always_ff @(posedge clk) begin
    if (cmd.text_en) begin
      char_r <= char_nxt;
    end
  end

  assign stat.alphabet_complete = complete_r;
  assign out_char_out           = char_r;

endmodule

/* sv/keyword_substitution_cipher_top.sv */
// top level of the keyword substitution cipher
//
// Input channel (in_valid/in_ready) carries one word: in_operation and in_char_in.
//   keyword byte: letters are uppercased and appended unless already used;
//     the first keyword byte after a finished alphabet starts a new keyword.
//   finish: the unused letters are appended Z down to A by the walk sequencer.
//   text byte: mapped by the alphabet, case kept; non-letters pass through,
//     and so does all text while a keyword is still being built.
// Result channel (out_valid/out_ready) carries out_char_out, one word per text byte.
// Config channel (cfg_valid/cfg_ready) writes decrypt_mode; write only while idle.
// A text result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle for keyword and text bytes while the output
//   is not stalled; a finish that builds the alphabet holds in_ready low while the
//   sequencer walks the letters one per cycle.
// Stall: the output register holds one result; when the receiver stalls,
//   in_ready drops until that result is taken.
// Reset: the alphabet is that of an empty keyword (Z down to A), encrypt mode.
`include "keyword_substitution_cipher_top_macros.svh"

module keyword_substitution_cipher_top
  import ksc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decrypt_mode
);

  ksc_cmd_t  cmd;
  ksc_stat_t stat;

  assign cfg_ready = 1'b1;

  // controller
  ksc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath
  ksc_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_char_in   (in_char_in),
    .mode_wr      (cfg_valid && cfg_ready),
    .mode_din     (cfg_decrypt_mode),
    .stat         (stat),
    .out_char_out (out_char_out)
  );

  // checks
  `KSC_ASSERT_SAME(a_walk_blocks_input, cmd.walk_en, !in_ready)
  `KSC_ASSERT_NEXT(a_text_gives_result, cmd.text_en, out_valid)
  `KSC_ASSERT_NEXT(a_walk_end_completes, cmd.walk_last, stat.alphabet_complete)

endmodule

/* bench/keyword_substitution_cipher_top_tb.sv */
// self-checking testbench for the keyword substitution cipher top level
module keyword_substitution_cipher_top_tb;
  import ksc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_operation;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char_out;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_decrypt_mode;

  int idle_pct;
  int stall_pct;
  int words_sent;

  // cipher alphabet tracker and expected output bytes
  class cipher_scoreboard;
    logic [LETTER_W-1:0] plain_to_cipher [NUM_LETTERS];
    logic [LETTER_W-1:0] cipher_to_plain [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] letters_taken;
    int  positions_filled;
    bit  alphabet_done;
    bit  decrypting;
    logic [7:0] expected_chars [$];
    int  mismatches;

    function new();
      for (int i = 0; i < NUM_LETTERS; i++) begin
        plain_to_cipher[i] = LETTER_W'(25 - i);
        cipher_to_plain[i] = LETTER_W'(25 - i);
      end
      letters_taken    = '1;
      positions_filled = NUM_LETTERS;
      alphabet_done    = 1'b1;
      decrypting       = 1'b0;
      mismatches       = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void append_letter(int k);
      if (positions_filled >= NUM_LETTERS) return;
      plain_to_cipher[positions_filled] = LETTER_W'(k);
      cipher_to_plain[k] = LETTER_W'(positions_filled);
      letters_taken[k] = 1'b1;
      positions_filled++;
    endfunction

    // update the alphabet for one accepted word, queue a byte for text
    function void note_word(logic [1:0] op, logic [7:0] ch);
      bit   is_letter;
      bit   is_lower;
      int   k;
      int   m;
      logic [7:0] r;
      is_letter = 1'b0;
      is_lower  = 1'b0;
      k = 0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
        is_letter = 1'b1;
        k = int'(ch - CHAR_UPPER_A);
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
        is_letter = 1'b1;
        is_lower  = 1'b1;
        k = int'(ch - CHAR_LOWER_A);
      end
      case (op)
        OP_KEY: begin
          // first keyword byte after a finished alphabet starts over
          if (alphabet_done) begin
            letters_taken    = '0;
            positions_filled = 0;
            alphabet_done    = 1'b0;
          end
          if (is_letter && !letters_taken[k]) append_letter(k);
        end
        OP_FINISH: begin
          // unused letters go in from z down to a
          if (!alphabet_done) begin
            for (int j = NUM_LETTERS - 1; j >= 0; j--) begin
              if (!letters_taken[j]) append_letter(j);
            end
            alphabet_done = 1'b1;
          end
        end
        OP_TEXT: begin
          r = ch;
          if (alphabet_done && is_letter) begin
            m = decrypting ? int'(cipher_to_plain[k]) : int'(plain_to_cipher[k]);
            if (m >= NUM_LETTERS) m = NUM_LETTERS - 1;
            r = (is_lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(m);
          end
          expected_chars.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task check_char(logic [7:0] got);
      logic [7:0] want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected output word %h", got));
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) report($sformatf("char_out got %h want %h", got, want));
      end
    endtask

    task check_leftover();
      if (expected_chars.size() != 0)
        report($sformatf("%0d output words never arrived", expected_chars.size()));
    endtask
  endclass

  cipher_scoreboard sb;

  keyword_substitution_cipher_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decrypt_mode(cfg_decrypt_mode)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // output side: check each word taken, stall at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_char(out_char_out);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // send one word, with random idle cycles ahead of it
  task send_word(input logic [1:0] op, input logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_char_in   <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, ch);
    words_sent++;
  endtask

  // hold the input until every expected word has come out
  task drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_chars.size() != 0);
  endtask

  // decrypt_mode is written only with the block idle, after results drain and any finish walk has ended
  task write_decrypt_mode(input bit mode);
    drain_results();
    repeat (40) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_decrypt_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.decrypting = mode;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_byte_mostly_letter(int letter_pct);
    if ($urandom_range(99) < letter_pct) return rand_letter();
    return 8'($urandom_range(255));
  endfunction

  // one keyword, finish, text run; sometimes noise instead
  task run_sequence();
    int kind;
    int n;
    int tmp;
    int pick;
    int order [NUM_LETTERS];
    kind = $urandom_range(99);
    if (kind < 80) begin
      if ($urandom_range(14) == 0) begin
        // full alphabet as keyword, shuffled, then a few repeats
        for (int i = 0; i < NUM_LETTERS; i++) order[i] = i;
        for (int i = NUM_LETTERS - 1; i > 0; i--) begin
          pick = $urandom_range(i);
          tmp = order[i];
          order[i] = order[pick];
          order[pick] = tmp;
        end
        for (int i = 0; i < NUM_LETTERS; i++)
          send_word(OP_KEY, ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(order[i]));
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) send_word(OP_KEY, rand_letter());
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(26, 40) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          send_word(OP_KEY, rand_byte_mostly_letter(80));
          // text while the keyword is still open passes through
          if ($urandom_range(19) == 0) send_word(OP_TEXT, rand_byte_mostly_letter(75));
        end
      end
      send_word(OP_FINISH, 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) send_word(OP_FINISH, 8'($urandom_range(255)));
      n = $urandom_range(4, 30);
      for (int i = 0; i < n; i++) send_word(OP_TEXT, rand_byte_mostly_letter(75));
    end else begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(2))
          0: send_word(OP_KEY, 8'($urandom_range(255)));
          1: send_word(OP_FINISH, 8'($urandom_range(255)));
          default: send_word(OP_TEXT, 8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // opening words: reset alphabet, boundary bytes, one short keyword
  logic [9:0] opening_words [23] = '{
    {OP_TEXT, 8'h41}, {OP_TEXT, 8'h7A}, {OP_TEXT, 8'h40}, {OP_TEXT, 8'h5B},
    {OP_TEXT, 8'h60}, {OP_TEXT, 8'h7B}, {OP_TEXT, 8'h00}, {OP_TEXT, 8'hFF},
    {OP_FINISH, 8'h00},
    {OP_KEY, 8'h6B}, {OP_KEY, 8'h45}, {OP_KEY, 8'h79}, {OP_KEY, 8'h4B},
    {OP_KEY, 8'h31}, {OP_KEY, 8'hFF}, {OP_KEY, 8'h80},
    {OP_TEXT, 8'h6D},
    {OP_FINISH, 8'hFF},
    {OP_TEXT, 8'h41}, {OP_TEXT, 8'h71}, {OP_TEXT, 8'h5A}, {OP_TEXT, 8'h61},
    {OP_FINISH, 8'h55}
  };

  int idle_by_phase  [4] = '{0, 57, 0, 32};
  int stall_by_phase [4] = '{0, 0, 57, 32};

  // stimulus and end of run
  initial begin
    int target;
    int r;
    sb = new();
    idle_pct   = 0;
    stall_pct  = 0;
    words_sent = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_KEY;
    in_char_in       <= 8'h00;
    cfg_valid        <= 1'b0;
    cfg_decrypt_mode <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    write_decrypt_mode(1'b0);
    foreach (opening_words[i]) send_word(opening_words[i][9:8], opening_words[i][7:0]);
    write_decrypt_mode(1'b1);
    send_word(OP_TEXT, 8'h4B);
    send_word(OP_TEXT, 8'h7A);

    // random part over idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      write_decrypt_mode(ph[0]);
      target = words_sent + 410;
      while (words_sent < target) begin
        run_sequence();
        r = $urandom_range(99);
        if (r < 2) write_decrypt_mode($urandom_range(1));
        else if (r < 5) drain_results();
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    sb.check_leftover();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ksc_pkg.sv
sv/ksc_ctrl.sv
sv/ksc_datapath.sv
sv/keyword_substitution_cipher_top.sv
bench/keyword_substitution_cipher_top_tb.sv
